/* sv/pcxrle_pkg.sv */
// ----------------------------------------------------------------------------
// pcxrle_pkg: shared types and constants for the PCX run-length blitter
// Command and pixel token formats, register indexes and dimension clamping.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

	// Largest image dimension honored; bigger register values saturate here.
	localparam int MaxDim = 4096;
	// Default depth of the command queue between front and back.
	localparam int CmdDepth = 4;

	localparam int DimW   = 13;
	localparam int PosW   = 12;
	localparam int CountW = 6;
	localparam int AddrW  = 24;
	localparam int PixW   = 8;
	localparam int IdxW   = 3;

	localparam logic [PixW-1:0]   RunMark   = 8'hBF;
	localparam logic [CountW-1:0] CountMask = 6'h3F;

	// Configuration register indexes.
	localparam logic [IdxW-1:0] RegImageWidth  = 3'd0;
	localparam logic [IdxW-1:0] RegImageHeight = 3'd1;
	localparam logic [IdxW-1:0] RegDestWidth   = 3'd2;
	localparam logic [IdxW-1:0] RegDestHeight  = 3'd3;
	localparam logic [IdxW-1:0] RegOriginX     = 3'd4;
	localparam logic [IdxW-1:0] RegOriginY     = 3'd5;
	localparam logic [IdxW-1:0] RegTransparent = 3'd6;

	typedef struct packed {
		logic [DimW-1:0] image_width;
		logic [DimW-1:0] image_height;
		logic [DimW-1:0] dest_width;
		logic [DimW-1:0] dest_height;
		logic [PosW-1:0] origin_x;
		logic [PosW-1:0] origin_y;
		logic            transparent;
	} cfg_t;

	// One decoded byte's worth of work for the back end.
	typedef struct packed {
		logic              start;
		logic [PixW-1:0]   value;
		logic [CountW-1:0] count;
	} cmd_t;

	// Token from the sequencer into the address pipeline.
	typedef struct packed {
		logic            valid;
		logic            is_end;
		logic            write;
		logic [DimW-1:0] dx;
		logic [DimW-1:0] dy;
		logic [PixW-1:0] value;
	} pix_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_RUN,
		SEQ_END
	} seq_state_t;

	// Saturate an image dimension to 1 .. MaxDim.
	function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
		logic [DimW-1:0] r;
		r = v;
		if (v == '0) begin
			r = DimW'(1);
		end else if (int'(v) > MaxDim) begin
			r = DimW'(MaxDim);
		end
		return r;
	endfunction

endpackage

/* sv/pcxrle_front.sv */
// ----------------------------------------------------------------------------
// pcxrle_front: byte parser
// Accepts compressed bytes, tracks run headers and queues one command per
// accepted byte, so the back end sees every byte in order.
// ----------------------------------------------------------------------------
module pcxrle_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [pcxrle_pkg::PixW-1:0] code_byte,
	input  logic                     start_image,
	input  logic                     fifo_full,
	output logic                     push,
	output pcxrle_pkg::cmd_t         push_cmd
);

	logic                            await_q;
	logic [pcxrle_pkg::CountW-1:0]   pend_q;
	logic                            await_d;
	logic [pcxrle_pkg::CountW-1:0]   pend_d;
	logic                            accept;

	assign in_ready = !fifo_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		await_d        = 1'b0;
		pend_d         = pend_q;
		push_cmd.start = start_image;
		push_cmd.value = code_byte;
		push_cmd.count = '0;
		if (await_q && !start_image) begin
			// value byte of a run; a zero run still lets the back end
			// notice an image that is already past its last row
			push_cmd.count = pend_q;
			pend_d         = '0;
		end else if (code_byte > pcxrle_pkg::RunMark) begin
			// header: queue an empty command for the end-of-image check
			await_d = 1'b1;
			pend_d  = code_byte[pcxrle_pkg::CountW-1:0] & pcxrle_pkg::CountMask;
		end else begin
			push_cmd.count = pcxrle_pkg::CountW'(1);
		end
	end

	assign push = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			await_q <= 1'b0;
			pend_q  <= '0;
		end else if (accept) begin
			await_q <= await_d;
			pend_q  <= pend_d;
		end
	end

endmodule

/* sv/pcxrle_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// pcxrle_cmd_fifo: command queue
// Small first-in first-out buffer decoupling the parser from the sequencer.
// ----------------------------------------------------------------------------
module pcxrle_cmd_fifo #(
	parameter int DEPTH = pcxrle_pkg::CmdDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pcxrle_pkg::cmd_t push_cmd,
	input  logic             pop,
	output pcxrle_pkg::cmd_t head_cmd,
	output logic             empty,
	output logic             full
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	pcxrle_pkg::cmd_t mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CntW'(DEPTH));
	assign head_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full || pop)
		else $error("command pushed into a full queue");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("command popped from an empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue fill count lost a push");

endmodule

/* sv/pcxrle_seq.sv */
// ----------------------------------------------------------------------------
// pcxrle_seq: run sequencer
// Walks the image position one pixel per cycle while en is high, decides
// clipping and transparency, and ends each pixel-placing command with a token.
// ----------------------------------------------------------------------------
module pcxrle_seq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pcxrle_pkg::cfg_t       cfg,
	input  pcxrle_pkg::cmd_t       head_cmd,
	input  logic                   empty,
	input  logic                   en,
	output logic                   pop,
	output pcxrle_pkg::pix_t       pix
);

	pcxrle_pkg::seq_state_t          state_q;
	pcxrle_pkg::seq_state_t          state_d;
	logic [pcxrle_pkg::PosW-1:0]     col_q;
	logic [pcxrle_pkg::DimW-1:0]     row_q;
	logic                            done_q;
	logic [pcxrle_pkg::CountW-1:0]   cnt_q;
	logic [pcxrle_pkg::PixW-1:0]     value_q;

	logic [pcxrle_pkg::DimW-1:0]     w_eff;
	logic [pcxrle_pkg::DimW-1:0]     h_eff;
	logic [pcxrle_pkg::PosW-1:0]     col_st;
	logic [pcxrle_pkg::DimW-1:0]     row_st;
	logic                            done_st;
	logic                            go;
	logic [pcxrle_pkg::DimW-1:0]     col_inc;
	logic                            wrap;
	logic [pcxrle_pkg::PosW-1:0]     col_nx;
	logic [pcxrle_pkg::DimW-1:0]     row_nx;
	logic                            run_over;

	assign w_eff = pcxrle_pkg::clamp_dim(cfg.image_width);
	assign h_eff = pcxrle_pkg::clamp_dim(cfg.image_height);

	// position as seen by the command at the head of the queue
	assign col_st  = head_cmd.start ? '0 : col_q;
	assign row_st  = head_cmd.start ? '0 : row_q;
	assign done_st = head_cmd.start ? 1'b0 : done_q;
	assign go      = !done_st && (row_st < h_eff) && (head_cmd.count != '0);

	assign col_inc  = {1'b0, col_q} + 1'b1;
	assign wrap     = (col_inc >= w_eff);
	assign col_nx   = wrap ? '0 : col_inc[pcxrle_pkg::PosW-1:0];
	assign row_nx   = wrap ? row_q + 1'b1 : row_q;
	assign run_over = (cnt_q == pcxrle_pkg::CountW'(1)) || (row_nx >= h_eff);

	always_comb begin
		state_d = state_q;
		case (state_q)
			pcxrle_pkg::SEQ_IDLE: begin
				if (pop && go) begin
					state_d = pcxrle_pkg::SEQ_RUN;
				end
			end
			pcxrle_pkg::SEQ_RUN: begin
				if (en && run_over) begin
					state_d = pcxrle_pkg::SEQ_END;
				end
			end
			pcxrle_pkg::SEQ_END: begin
				if (en) begin
					state_d = pcxrle_pkg::SEQ_IDLE;
				end
			end
			default: state_d = pcxrle_pkg::SEQ_IDLE;
		endcase
	end

	always_comb begin
		pop        = 1'b0;
		pix.valid  = 1'b0;
		pix.is_end = 1'b0;
		pix.value  = value_q;
		pix.dx     = {1'b0, cfg.origin_x} + {1'b0, col_q};
		pix.dy     = {1'b0, cfg.origin_y} + row_q;
		pix.write  = (pix.dx < cfg.dest_width) && (pix.dy < cfg.dest_height)
			&& !(cfg.transparent && (value_q == '0));
		case (state_q)
			pcxrle_pkg::SEQ_IDLE: pop = en && !empty;
			pcxrle_pkg::SEQ_RUN:  pix.valid = 1'b1;
			pcxrle_pkg::SEQ_END: begin
				pix.valid  = 1'b1;
				pix.is_end = 1'b1;
			end
			default: pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcxrle_pkg::SEQ_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			value_q <= '0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				col_q   <= col_st;
				row_q   <= row_st;
				done_q  <= done_st || (row_st >= h_eff);
				cnt_q   <= head_cmd.count;
				value_q <= head_cmd.value;
			end else if (state_q == pcxrle_pkg::SEQ_RUN && en) begin
				col_q  <= col_nx;
				row_q  <= row_nx;
				done_q <= (row_nx >= h_eff);
				cnt_q  <= cnt_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pcxrle_pkg::SEQ_RUN |-> cnt_q != '0 && !done_q)
		else $error("running with no pixels left or a finished image");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pcxrle_pkg::SEQ_RUN |-> row_q < h_eff)
		else $error("placing a pixel below the last image row");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> state_q == pcxrle_pkg::SEQ_END || state_q == pcxrle_pkg::SEQ_IDLE)
		else $error("image finished while a run is still being placed");

endmodule

/* sv/pcxrle_addr.sv */
// ----------------------------------------------------------------------------
// pcxrle_addr: address pipeline and output stage
// Forms row * pitch + column, holds one write back so the last write of a
// byte can be flagged, and drives the result channel.
// ----------------------------------------------------------------------------
module pcxrle_addr (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pcxrle_pkg::pix_t              pix,
	input  logic [pcxrle_pkg::DimW-1:0]   dest_width,
	output logic                          en,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pcxrle_pkg::AddrW-1:0]  pixel_address,
	output logic [pcxrle_pkg::PixW-1:0]   pixel_value,
	output logic                          last_of_run
);

	pcxrle_pkg::pix_t                 pix_s1;
	logic                             valid_s2;
	logic                             is_end_s2;
	logic                             write_s2;
	logic [pcxrle_pkg::DimW-1:0]      dx_s2;
	logic [pcxrle_pkg::PixW-1:0]      value_s2;
	logic [pcxrle_pkg::AddrW-1:0]     prod_s2;
	logic [2*pcxrle_pkg::DimW-1:0]    prod_full;

	logic                             held_valid_q;
	logic [pcxrle_pkg::AddrW-1:0]     held_addr_q;
	logic [pcxrle_pkg::PixW-1:0]      held_value_q;
	logic                             out_valid_q;
	logic [pcxrle_pkg::AddrW-1:0]     out_addr_q;
	logic [pcxrle_pkg::PixW-1:0]      out_value_q;
	logic                             out_last_q;

	logic [pcxrle_pkg::AddrW-1:0]     addr_s2;
	logic                             take;
	logic                             flush;
	logic                             emit;

	// whole back pipeline advances together when the output slot frees
	assign en = !out_valid_q || out_ready;

	assign prod_full = pix_s1.dy * dest_width;
	assign addr_s2   = prod_s2 + pcxrle_pkg::AddrW'(dx_s2);
	assign take      = valid_s2 && !is_end_s2 && write_s2;
	assign flush     = valid_s2 && is_end_s2;
	assign emit      = held_valid_q && (take || flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s1       <= '0;
			valid_s2     <= 1'b0;
			is_end_s2    <= 1'b0;
			held_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else if (en) begin
			pix_s1      <= pix;
			valid_s2    <= pix_s1.valid;
			is_end_s2   <= pix_s1.is_end;
			out_valid_q <= emit;
			if (take) begin
				held_valid_q <= 1'b1;
			end else if (flush) begin
				held_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			write_s2 <= pix_s1.write;
			dx_s2    <= pix_s1.dx;
			value_s2 <= pix_s1.value;
			prod_s2  <= prod_full[pcxrle_pkg::AddrW-1:0];
			if (take) begin
				held_addr_q  <= addr_s2;
				held_value_q <= value_s2;
			end
			if (emit) begin
				out_addr_q  <= held_addr_q;
				out_value_q <= held_value_q;
				out_last_q  <= flush;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_address = out_addr_q;
	assign pixel_value   = out_value_q;
	assign last_of_run   = out_last_q;

endmodule

/* sv/pcx_rle_decode_blit.sv */
// ----------------------------------------------------------------------------
// pcx_rle_decode_blit: PCX run-length decoder with clipped blit
// Decodes a PCX byte stream and emits one addressed write per visible pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one compressed byte per transfer, with
//   start_image set on the first byte of an image. A byte above 0xBF is a run
//   header (low six bits = count); the next byte is the repeated value.
//   Output channel (out_valid/out_ready): one transfer per written pixel with
//   its linear address (row * dest_width + column, modulo 2^24) and value;
//   last_of_run flags the final write caused by one input byte.
//   Configuration: cfg_we/cfg_index/cfg_data write a register;
//   write only while the block is idle.
// Sequencing: each accepted byte queues one command. A header, a zero run or
//   a byte of a finished image takes only a queue fetch; a literal or a run
//   takes a queue fetch, its pixels at one per cycle while the output is not
//   stalled, and an end-of-byte token.
// Path: the last write of a byte passes through the command queue, the
//   sequencer registers, stages s1 and s2, the held write and the output
//   register, in that order.
// Reset clears the parser, the command queue, position and image-done state,
//   and sets the registers to a 1x1 image in a 1x1 buffer at origin 0.
// A stalled receiver freezes the back end; the command queue, four entries by
//   default, keeps accepting bytes until it fills, then in_ready drops.
// ----------------------------------------------------------------------------
module pcx_rle_decode_blit #(
	parameter int CMD_DEPTH = pcxrle_pkg::CmdDepth
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pcxrle_pkg::IdxW-1:0]   cfg_index,
	input  logic [pcxrle_pkg::DimW-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pcxrle_pkg::PixW-1:0]   code_byte,
	input  logic                          start_image,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pcxrle_pkg::AddrW-1:0]  pixel_address,
	output logic [pcxrle_pkg::PixW-1:0]   pixel_value,
	output logic                          last_of_run
);

	pcxrle_pkg::cfg_t cfg_q;
	pcxrle_pkg::cmd_t push_cmd;
	pcxrle_pkg::cmd_t head_cmd;
	pcxrle_pkg::pix_t pix;
	logic             push;
	logic             pop;
	logic             empty;
	logic             full;
	logic             en;

	// Configuration registers: take each write on the enable, drop unknown
	// indexes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= pcxrle_pkg::DimW'(1);
			cfg_q.image_height <= pcxrle_pkg::DimW'(1);
			cfg_q.dest_width   <= pcxrle_pkg::DimW'(1);
			cfg_q.dest_height  <= pcxrle_pkg::DimW'(1);
			cfg_q.origin_x     <= '0;
			cfg_q.origin_y     <= '0;
			cfg_q.transparent  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				pcxrle_pkg::RegImageWidth:  cfg_q.image_width  <= cfg_data;
				pcxrle_pkg::RegImageHeight: cfg_q.image_height <= cfg_data;
				pcxrle_pkg::RegDestWidth:   cfg_q.dest_width   <= cfg_data;
				pcxrle_pkg::RegDestHeight:  cfg_q.dest_height  <= cfg_data;
				pcxrle_pkg::RegOriginX:
					cfg_q.origin_x <= cfg_data[pcxrle_pkg::PosW-1:0];
				pcxrle_pkg::RegOriginY:
					cfg_q.origin_y <= cfg_data[pcxrle_pkg::PosW-1:0];
				pcxrle_pkg::RegTransparent: cfg_q.transparent  <= cfg_data[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// Front: parse bytes into commands.
	pcxrle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.code_byte  (code_byte),
		.start_image(start_image),
		.fifo_full  (full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	// Queue between the parser and the pixel walk.
	pcxrle_cmd_fifo #(
		.DEPTH(CMD_DEPTH)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head_cmd(head_cmd),
		.empty   (empty),
		.full    (full)
	);

	// Back: walk positions, clip, then form addresses.
	pcxrle_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.head_cmd(head_cmd),
		.empty   (empty),
		.en      (en),
		.pop     (pop),
		.pix     (pix)
	);

	pcxrle_addr u_addr (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix          (pix),
		.dest_width   (cfg_q.dest_width),
		.en           (en),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_address(pixel_address),
		.pixel_value  (pixel_value),
		.last_of_run  (last_of_run)
	);

endmodule
